@@ hw/rtl/fljac_pkg.sv @@
`default_nettype none
package fljac_pkg;

    localparam int FEATURES      = 64;
    localparam int LEAVES        = 256;
    localparam int PAIRS         = 1024;
    localparam int FRACTION_BITS = 16;

    localparam int ROW_W   = 64;
    localparam int LEAF_W  = 8;
    localparam int PAIR_W  = 10;
    localparam int SUM_W   = 27;
    localparam int CNT_W   = $clog2(FEATURES + 1);
    localparam int RATIO_W = FRACTION_BITS + 1;
    localparam int DIVD_W  = CNT_W + FRACTION_BITS;
    localparam int STEP_W  = $clog2(DIVD_W + 1);

    localparam logic [ROW_W-1:0] FEAT_MASK = {ROW_W{1'b1}} >> (ROW_W - FEATURES);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_PAIR = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_START,
        S_DIV,
        S_ACC
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [LEAF_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
        logic              rd_en;
        logic [LEAF_W-1:0] rd_addr;
    } t_leaf_cmd;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [PAIR_W-1:0]  addr;
        logic [RATIO_W-1:0] ratio;
        logic               first;
    } t_sum_cmd;

    // Adder tree over the 64 row bits, six levels of narrow adds
    function automatic logic [CNT_W-1:0] count_ones(input logic [ROW_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
        for (int i = 0; i < 16; i++) l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
        for (int i = 0; i < 8; i++)  l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
        for (int i = 0; i < 4; i++)  l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
        for (int i = 0; i < 2; i++)  l5[i] = 6'(l4[2*i]) + 6'(l4[2*i+1]);
        return CNT_W'(l5[0]) + CNT_W'(l5[1]);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fljac_leaf_store.sv @@
`default_nettype none
module fljac_leaf_store
    import fljac_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_leaf_cmd        i_cmd,
    output logic [ROW_W-1:0]      o_rd_data
);

    logic [ROW_W-1:0] r_mem [LEAVES];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
    end

    // Registered read; hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ hw/rtl/fljac_div.sv @@
`default_nettype none
module fljac_div
    import fljac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIVD_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [RATIO_W-1:0]      o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [DIVD_W-1:0] r_quo;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W-1:0]  n_rem;

    // Restoring step: shift in one dividend bit, subtract if the divisor fits
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[RATIO_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/fljac_pair_acc.sv @@
`default_nettype none
module fljac_pair_acc
    import fljac_pkg::*;
(
    input  wire logic          i_clk,
    input  wire t_sum_cmd      i_cmd,
    output logic [SUM_W-1:0]   o_sum
);

    logic [SUM_W-1:0] r_mem [PAIRS];
    logic [SUM_W-1:0] r_rd_data;
    logic [SUM_W:0]   wide;
    logic [SUM_W-1:0] n_sum;

    // Restart on the first tree, else add; saturate at the top of the range
    always_comb begin
        wide  = (i_cmd.first ? '0 : {1'b0, r_rd_data}) + (SUM_W + 1)'(i_cmd.ratio);
        n_sum = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= n_sum;
        end
    end

    assign o_sum = n_sum;

endmodule
`default_nettype wire

@@ hw/rtl/forest_leaf_jaccard_accumulator_top.sv @@
`default_nettype none
// Load word: taken while idle, the leaf row is written at the accepting edge.
// Pair word: states RDA, RDB, START, DIV (the bit-serial divider) and ACC, then
// the result word is valid; the next word is taken once the sequencer is in IDLE.
// Reset (synchronous, active low) clears the sequencer, divider and output
// valid; leaf rows and pair sums are undefined until written.
module forest_leaf_jaccard_accumulator_top
    import fljac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [LEAF_W-1:0]  i_leaf_index,
    input  wire logic [ROW_W-1:0]   i_leaf_bits,
    input  wire logic [PAIR_W-1:0]  i_pair_index,
    input  wire logic [LEAF_W-1:0]  i_leaf_a,
    input  wire logic [LEAF_W-1:0]  i_leaf_b,
    input  wire logic               i_first_tree,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [PAIR_W-1:0]       o_result_pair,
    output logic [SUM_W-1:0]        o_similarity_sum,
    output logic                    o_empty_union
);

    t_state r_state, n_state;

    // Per-word working registers
    logic [ROW_W-1:0]  r_row_a;
    logic [LEAF_W-1:0] r_leaf_b;
    logic [PAIR_W-1:0] r_pair;
    logic              r_first;
    logic [CNT_W-1:0]  r_inter;
    logic [CNT_W-1:0]  r_uni;

    // Output register: parts the sequencer from the downstream stall
    logic              r_out_valid;
    logic [PAIR_W-1:0] r_out_pair;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_empty;

    logic              in_acc;
    logic              out_acc;
    logic              out_load;
    logic              w_empty;
    logic              div_start;
    logic              div_done;
    logic [RATIO_W-1:0] div_quo;
    logic [ROW_W-1:0]  leaf_rd;
    logic [SUM_W-1:0]  acc_sum;
    t_leaf_cmd         leaf_cmd;
    t_sum_cmd          sum_cmd;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    // Union of two all-zero rows: ratio forced to zero, flag raised
    assign w_empty = (r_uni == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_command == CMD_PAIR)) n_state = S_RDA;
            end
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = S_ACC;
            end
            S_ACC: begin
                // Wait here while the previous result still sits unclaimed
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_stall   = 1'b1;
        div_start = 1'b0;
        out_load  = 1'b0;

        leaf_cmd.wr_en   = 1'b0;
        leaf_cmd.wr_addr = i_leaf_index;
        leaf_cmd.wr_data = i_leaf_bits;
        leaf_cmd.rd_en   = 1'b0;
        leaf_cmd.rd_addr = i_leaf_a;

        sum_cmd.rd_en = 1'b0;
        sum_cmd.wr_en = 1'b0;
        sum_cmd.addr  = r_pair;
        sum_cmd.ratio = w_empty ? '0 : div_quo;
        sum_cmd.first = r_first;

        unique case (r_state)
            S_IDLE: begin
                o_stall        = 1'b0;
                leaf_cmd.wr_en = in_acc && (i_command == CMD_LOAD);
                leaf_cmd.rd_en = in_acc && (i_command == CMD_PAIR);
            end
            S_RDA: begin
                leaf_cmd.rd_en   = 1'b1;
                leaf_cmd.rd_addr = r_leaf_b;
            end
            S_RDB: begin
            end
            S_START: begin
                div_start     = 1'b1;
                sum_cmd.rd_en = 1'b1;
            end
            S_DIV: begin
            end
            S_ACC: begin
                out_load      = !r_out_valid || !i_stall;
                sum_cmd.wr_en = out_load;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the pair fields on acceptance
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_leaf_b <= i_leaf_b;
            r_pair   <= i_pair_index;
            r_first  <= i_first_tree;
        end
    end

    // Row A is read out in S_RDA, row B in S_RDB; count both sets then
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDA) begin
            r_row_a <= leaf_rd;
        end
        if (r_state == S_RDB) begin
            r_inter <= count_ones(r_row_a & leaf_rd & FEAT_MASK);
            r_uni   <= count_ones((r_row_a | leaf_rd) & FEAT_MASK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pair  <= r_pair;
            r_out_sum   <= acc_sum;
            r_out_empty <= w_empty;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_pair    = r_out_pair;
    assign o_similarity_sum = r_out_sum;
    assign o_empty_union    = r_out_empty;

    fljac_leaf_store u_leaf_store (
        .i_clk     (i_clk),
        .i_cmd     (leaf_cmd),
        .o_rd_data (leaf_rd)
    );

    // Ratio = (intersection << FRACTION_BITS) / union, truncated
    fljac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_inter, FRACTION_BITS'(0)}),
        .i_divisor  (r_uni),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    fljac_pair_acc u_pair_acc (
        .i_clk (i_clk),
        .i_cmd (sum_cmd),
        .o_sum (acc_sum)
    );

`ifndef NO_ASSERTIONS
    a_pair_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_PAIR)) |=> (r_state == S_RDA))
        else $error("pair word did not start the read sequence");

    a_write_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_cmd.wr_en |=> (o_valid && (o_result_pair == $past(r_pair))))
        else $error("sum write without matching result word");

    a_ratio_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && div_done && !w_empty) |->
            (div_quo <= RATIO_W'(1 << FRACTION_BITS)))
        else $error("ratio above one");

    a_empty_fresh : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sum_cmd.wr_en && w_empty && r_first) |=> (o_similarity_sum == '0))
        else $error("empty union on first tree gave a nonzero sum");
`endif

endmodule
`default_nettype wire

@@ dv/jaccard_sum_checker.sv @@
`default_nettype none
module jaccard_sum_checker
    import fljac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic              i_command,
    input  wire logic [LEAF_W-1:0] i_leaf_index,
    input  wire logic [ROW_W-1:0]  i_leaf_bits,
    input  wire logic [PAIR_W-1:0] i_pair_index,
    input  wire logic [LEAF_W-1:0] i_leaf_a,
    input  wire logic [LEAF_W-1:0] i_leaf_b,
    input  wire logic              i_first_tree,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [PAIR_W-1:0] i_result_pair,
    input  wire logic [SUM_W-1:0]  i_similarity_sum,
    input  wire logic              i_empty_union,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [SUM_W-1:0]  sum;
        logic              empty;
    } t_sum_word;

    logic [ROW_W-1:0] leaf_store [LEAVES];
    logic [SUM_W-1:0] running_sums [PAIRS];
    t_sum_word        sums_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Jaccard ratio of two leaf rows, folded into the slot's running sum
    function automatic t_sum_word accumulate_pair(input logic [PAIR_W-1:0] slot,
                                                  input logic [LEAF_W-1:0] leaf_a,
                                                  input logic [LEAF_W-1:0] leaf_b,
                                                  input logic              first);
        logic [ROW_W-1:0] row_a;
        logic [ROW_W-1:0] row_b;
        int unsigned      both;
        int unsigned      either;
        logic [63:0]      ratio;
        logic [SUM_W:0]   total;
        t_sum_word        word;
        row_a  = ((int'(leaf_a) < LEAVES) ? leaf_store[leaf_a] : '0) & FEAT_MASK;
        row_b  = ((int'(leaf_b) < LEAVES) ? leaf_store[leaf_b] : '0) & FEAT_MASK;
        both   = $countones(row_a & row_b);
        either = $countones(row_a | row_b);
        ratio  = (either == 0) ? 64'd0 : (64'(both) << FRACTION_BITS) / 64'(either);
        if (first) begin
            total = ratio[SUM_W:0];
        end else begin
            total = {1'b0, running_sums[slot]} + ratio[SUM_W:0];
        end
        if (total > {1'b0, SUM_MAX}) begin
            total = {1'b0, SUM_MAX};
        end
        running_sums[slot] = total[SUM_W-1:0];
        word.pair  = slot;
        word.sum   = total[SUM_W-1:0];
        word.empty = (either == 0);
        return word;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sum_word due;
        if (i_rst_n) begin
            // retire results before taking new words, so a fresh one never matches
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (sums_due.size() == 0) begin
                    $error("result word for pair %0d arrived with none expected",
                           i_result_pair);
                    o_fail_count++;
                end else begin
                    due = sums_due.pop_front();
                    if (i_result_pair !== due.pair) begin
                        $error("result_pair: expected %0d, got %0d", due.pair, i_result_pair);
                        o_fail_count++;
                    end
                    if (i_similarity_sum !== due.sum) begin
                        $error("similarity_sum: expected %0d, got %0d",
                               due.sum, i_similarity_sum);
                        o_fail_count++;
                    end
                    if (i_empty_union !== due.empty) begin
                        $error("empty_union: expected %0d, got %0d", due.empty, i_empty_union);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (i_command == CMD_LOAD) begin
                    if (int'(i_leaf_index) < LEAVES) leaf_store[i_leaf_index] = i_leaf_bits;
                end else if (int'(i_pair_index) < PAIRS) begin
                    sums_due.push_back(accumulate_pair(i_pair_index, i_leaf_a, i_leaf_b,
                                                       i_first_tree));
                end
            end
        end
        o_pending = sums_due.size();
    end

endmodule
`default_nettype wire

@@ dv/tb_forest_leaf_jaccard_accumulator_top.sv @@
`default_nettype none
module tb_forest_leaf_jaccard_accumulator_top;
    import fljac_pkg::*;

    localparam int RANDOM_WORDS  = 530;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 1000000;

    // Inputs of the block, all known from time zero
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_stall      = 1'b0;
    logic              i_command    = CMD_LOAD;
    logic [LEAF_W-1:0] i_leaf_index = '0;
    logic [ROW_W-1:0]  i_leaf_bits  = '0;
    logic [PAIR_W-1:0] i_pair_index = '0;
    logic [LEAF_W-1:0] i_leaf_a     = '0;
    logic [LEAF_W-1:0] i_leaf_b     = '0;
    logic              i_first_tree = 1'b0;

    logic              o_stall;
    logic              o_valid;
    logic [PAIR_W-1:0] o_result_pair;
    logic [SUM_W-1:0]  o_similarity_sum;
    logic              o_empty_union;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;

    // Stimulus bookkeeping: only written leaves are read, and a sum is only
    // added to once its slot has been started by a first-tree word
    bit leaf_loaded  [LEAVES];
    int loaded_leaves [$];
    bit slot_started [PAIRS];
    int started_slots [$];

    always #5 i_clk = ~i_clk;

    forest_leaf_jaccard_accumulator_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_leaf_index     (i_leaf_index),
        .i_leaf_bits      (i_leaf_bits),
        .i_pair_index     (i_pair_index),
        .i_leaf_a         (i_leaf_a),
        .i_leaf_b         (i_leaf_b),
        .i_first_tree     (i_first_tree),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_pair    (o_result_pair),
        .o_similarity_sum (o_similarity_sum),
        .o_empty_union    (o_empty_union)
    );

    jaccard_sum_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_command        (i_command),
        .i_leaf_index     (i_leaf_index),
        .i_leaf_bits      (i_leaf_bits),
        .i_pair_index     (i_pair_index),
        .i_leaf_a         (i_leaf_a),
        .i_leaf_b         (i_leaf_b),
        .i_first_tree     (i_first_tree),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_result_pair    (o_result_pair),
        .i_similarity_sum (o_similarity_sum),
        .i_empty_union    (o_empty_union),
        .o_fail_count     (fail_count),
        .o_pending        (words_pending)
    );

    // Receiver back-pressure: stall with a chance of 31 in a hundred, none in the quiet stretch
    always @(negedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(99) < 31);
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one word at a falling edge and hold it until taken. Valid stays
    // high on return, so with gaps off back-to-back words never drop it.
    task automatic send_word(input logic              cmd,
                             input logic [LEAF_W-1:0] leaf_index,
                             input logic [ROW_W-1:0]  bits,
                             input logic [PAIR_W-1:0] slot,
                             input logic [LEAF_W-1:0] leaf_a,
                             input logic [LEAF_W-1:0] leaf_b,
                             input logic              first);
        while (gaps_on && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_leaf_index <= leaf_index;
        i_leaf_bits  <= bits;
        i_pair_index <= slot;
        i_leaf_a     <= leaf_a;
        i_leaf_b     <= leaf_b;
        i_first_tree <= first;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == CMD_LOAD && !leaf_loaded[leaf_index]) begin
            leaf_loaded[leaf_index] = 1'b1;
            loaded_leaves.push_back(leaf_index);
        end
        if (cmd == CMD_PAIR && !slot_started[slot]) begin
            slot_started[slot] = 1'b1;
            started_slots.push_back(slot);
        end
    endtask

    // Load word: the pair-side fields carry noise
    task automatic load_leaf(input logic [LEAF_W-1:0] leaf, input logic [ROW_W-1:0] bits);
        send_word(CMD_LOAD, leaf, bits, PAIR_W'($urandom), LEAF_W'($urandom),
                  LEAF_W'($urandom), 1'($urandom));
    endtask

    // Pair word: the load-side fields carry noise
    task automatic pair_up(input logic [PAIR_W-1:0] slot, input logic [LEAF_W-1:0] leaf_a,
                           input logic [LEAF_W-1:0] leaf_b, input logic first);
        send_word(CMD_PAIR, LEAF_W'($urandom), {$urandom, $urandom}, slot, leaf_a, leaf_b,
                  first);
    endtask

    // Drop valid and hold off until every expected sum has come back
    task automatic drain_sums();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (words_pending != 0);
    endtask

    // Rows of varied density, so the ratios spread over the whole range
    function automatic logic [ROW_W-1:0] random_row();
        case ($urandom_range(7))
            0, 1:    return {$urandom, $urandom};
            2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3:       return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
            4:       return {$urandom, $urandom} & ({ROW_W{1'b1}} >> $urandom_range(63));
            5:       return ROW_W'(1) << $urandom_range(63);
            6:       return '0;
            default: return '1;
        endcase
    endfunction

    initial begin : stimulus
        logic [LEAF_W-1:0] leaf_a;
        logic [LEAF_W-1:0] leaf_b;
        logic [PAIR_W-1:0] slot;
        logic              first;

        // Synchronous reset, held and then released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: row extremes, exact and truncated ratios, disjoint rows,
        // the empty union, restart of a live sum and the top and bottom slots
        load_leaf(8'd0,   '0);
        load_leaf(8'd255, '1);
        load_leaf(8'd1,   {16{4'hA}});
        load_leaf(8'd2,   {16{4'h5}});
        load_leaf(8'd128, 64'h1);
        load_leaf(8'd127, 64'h8000_0000_0000_0000);
        load_leaf(8'd3,   64'h7);
        pair_up(10'd0,    8'd0,   8'd0,   1'b1);   // both rows empty
        pair_up(10'd1023, 8'd255, 8'd255, 1'b1);   // full-scale ratio
        pair_up(10'd1023, 8'd255, 8'd1,   1'b0);   // add one half
        pair_up(10'd1,    8'd1,   8'd2,   1'b1);   // disjoint halves
        pair_up(10'd2,    8'd0,   8'd255, 1'b1);   // one empty row only
        pair_up(10'd512,  8'd128, 8'd255, 1'b1);   // one in sixty-four
        pair_up(10'd512,  8'd127, 8'd128, 1'b0);   // single bits at both ends
        pair_up(10'd3,    8'd3,   8'd128, 1'b1);   // one third, truncated
        pair_up(10'd3,    8'd128, 8'd3,   1'b0);
        pair_up(10'd0,    8'd0,   8'd0,   1'b0);   // empty union onto a live sum
        pair_up(10'd1023, 8'd0,   8'd255, 1'b1);   // restart a live sum
        load_leaf(8'd1, '0);                        // overwrite a row in use
        pair_up(10'd1,    8'd1,   8'd2,   1'b0);
        drain_sums();

        // Random: mostly pair words over written leaves, with loads mixed in.
        // Words 250 to 349 run with no idling on either side.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = !(n >= 250 && n < 350);
            if (n == 400) drain_sums();
            if ($urandom_range(99) < 30) begin
                load_leaf(LEAF_W'($urandom), random_row());
            end else begin
                leaf_a = LEAF_W'(loaded_leaves[$urandom_range(loaded_leaves.size() - 1)]);
                leaf_b = LEAF_W'(loaded_leaves[$urandom_range(loaded_leaves.size() - 1)]);
                if ($urandom_range(7) == 0) leaf_b = leaf_a;
                if ($urandom_range(99) < 60) begin
                    slot = PAIR_W'(started_slots[$urandom_range(started_slots.size() - 1)]);
                end else begin
                    slot = PAIR_W'($urandom);
                end
                first = slot_started[slot] ? ($urandom_range(99) < 15) : 1'b1;
                pair_up(slot, leaf_a, leaf_b, first);
            end
        end
        gaps_on = 1'b1;

        drain_sums();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ forest_leaf_jaccard_accumulator_top.f @@
hw/rtl/fljac_pkg.sv
hw/rtl/fljac_leaf_store.sv
hw/rtl/fljac_div.sv
hw/rtl/fljac_pair_acc.sv
hw/rtl/forest_leaf_jaccard_accumulator_top.sv
dv/jaccard_sum_checker.sv
dv/tb_forest_leaf_jaccard_accumulator_top.sv
